>>> rtl/core/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, register codes and reset constants of the touch pad press
// classifier.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Default geometry
    localparam int TPC_NUM_PADS      = 9;
    localparam int TPC_HISTORY_DEPTH = 4;

    // Fixed field widths
    localparam int TPC_PAD_FIELD_W = 4;
    localparam int TPC_SAMPLE_W    = 16;
    localparam int TPC_TIME_W      = 32;
    localparam int TPC_CFG_W       = 16;
    localparam int TPC_DELTA_W     = TPC_SAMPLE_W + 1;
    localparam int TPC_CFG_IDX_W   = 3;

    // Register reset values
    localparam logic [TPC_CFG_W-1:0] TPC_RST_THRESHOLD  = 16'd150;
    localparam logic [TPC_CFG_W-1:0] TPC_RST_SHORT_MS   = 16'd1000;
    localparam logic [TPC_CFG_W-1:0] TPC_RST_LONG_MS    = 16'd3000;
    localparam logic [TPC_CFG_W-1:0] TPC_RST_VLONG_MS   = 16'd5000;
    localparam logic [TPC_CFG_W-1:0] TPC_RST_STUCK_MS   = 16'd7000;
    localparam logic                 TPC_RST_TOUCH_EN   = 1'b0;

    // Event codes, also used as the per-pad state encoding
    typedef enum logic [2:0] {
        EV_TOUCHED   = 3'd0,
        EV_RELEASED  = 3'd1,
        EV_SHORT     = 3'd2,
        EV_LONG      = 3'd3,
        EV_VERY_LONG = 3'd4
    } t_event_code;

    // Configuration register indexes
    typedef enum logic [TPC_CFG_IDX_W-1:0] {
        CFG_DELTA_THRESHOLD = 3'd0,
        CFG_SHORT_PRESS_MS  = 3'd1,
        CFG_LONG_PRESS_MS   = 3'd2,
        CFG_VLONG_PRESS_MS  = 3'd3,
        CFG_STUCK_RELEASE   = 3'd4,
        CFG_TOUCH_ENABLED   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [TPC_CFG_W-1:0] delta_threshold;
        logic [TPC_CFG_W-1:0] short_press_ms;
        logic [TPC_CFG_W-1:0] long_press_ms;
        logic [TPC_CFG_W-1:0] very_long_press_ms;
        logic [TPC_CFG_W-1:0] stuck_release_ms;
        logic                 touch_enabled;
    } t_cfg;

    // Fixed-width part of one pad's record
    typedef struct packed {
        t_event_code             state;
        logic [TPC_TIME_W-1:0]   change_time;
        logic [TPC_SAMPLE_W-1:0] last_sample;
    } t_pad_ctl;

    typedef struct packed {
        logic [TPC_PAD_FIELD_W-1:0] pad_index;
        logic [TPC_SAMPLE_W-1:0]    raw_sample;
        logic [TPC_TIME_W-1:0]      now_ms;
    } t_in_item;

    typedef struct packed {
        logic [TPC_PAD_FIELD_W-1:0] event_pad;
        t_event_code                event_code;
    } t_out_item;

endpackage

>>> rtl/core/tpc_pad_update.sv
// ----------------------------------------------------------------------------
// tpc_pad_update
// Next-state logic of one pad: delta, ring and running sum update, then the
// touch / release / press escalation decision.
// ----------------------------------------------------------------------------
module tpc_pad_update #(
    parameter int HISTORY_DEPTH = tpc_pkg::TPC_HISTORY_DEPTH,
    parameter int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
    parameter int SUM_W         = tpc_pkg::TPC_DELTA_W + $clog2(HISTORY_DEPTH)
) (
    input  tpc_pkg::t_cfg                                          i_cfg,
    input  logic [tpc_pkg::TPC_SAMPLE_W-1:0]                       i_sample,
    input  logic [tpc_pkg::TPC_TIME_W-1:0]                         i_now,
    input  tpc_pkg::t_pad_ctl                                      i_ctl,
    input  logic [HISTORY_DEPTH-1:0][tpc_pkg::TPC_DELTA_W-1:0]     i_ring,
    input  logic [PTR_W-1:0]                                       i_ptr,
    input  logic signed [SUM_W-1:0]                                i_sum,
    output tpc_pkg::t_pad_ctl                                      o_ctl,
    output logic [HISTORY_DEPTH-1:0][tpc_pkg::TPC_DELTA_W-1:0]     o_ring,
    output logic [PTR_W-1:0]                                       o_ptr,
    output logic signed [SUM_W-1:0]                                o_sum,
    output logic                                                   o_emit,
    output tpc_pkg::t_event_code                                   o_code
);
    import tpc_pkg::*;

    logic signed [TPC_DELTA_W-1:0] delta;
    logic signed [TPC_DELTA_W-1:0] old_delta;
    logic [SUM_W-1:0]              mag;
    logic [TPC_TIME_W-1:0]         elapsed;
    logic                          over_thr;

    // Delta against the previous sample; a zero previous sample means no history
    always_comb begin
        if (i_ctl.last_sample == '0) begin
            delta = '0;
        end else begin
            delta = $signed({1'b0, i_sample}) - $signed({1'b0, i_ctl.last_sample});
        end
    end

    // Replace the oldest ring entry and adjust the running sum
    assign old_delta = $signed(i_ring[i_ptr]);
    assign o_sum     = i_sum - SUM_W'(old_delta) + SUM_W'(delta);
    assign mag       = o_sum[SUM_W-1] ? $unsigned(-o_sum) : $unsigned(o_sum);
    assign over_thr  = mag > SUM_W'(i_cfg.delta_threshold);
    assign elapsed   = i_now - i_ctl.change_time;

    always_comb begin
        o_ring        = i_ring;
        o_ring[i_ptr] = delta;
        o_ptr = (i_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : i_ptr + 1'b1;
    end

    // Classify: swing detection first, then time-based escalation
    always_comb begin
        o_ctl             = i_ctl;
        o_ctl.last_sample = i_sample;
        o_emit            = 1'b0;
        o_code            = EV_TOUCHED;
        if (over_thr) begin
            if (delta[TPC_DELTA_W-1]) begin
                if (i_ctl.state == EV_RELEASED) begin
                    o_ctl.state       = EV_TOUCHED;
                    o_ctl.change_time = i_now;
                    o_emit            = 1'b1;
                    o_code            = EV_TOUCHED;
                end
            end else if (i_ctl.state != EV_RELEASED) begin
                o_ctl.state       = EV_RELEASED;
                o_ctl.change_time = i_now;
                o_emit            = 1'b1;
                o_code            = EV_RELEASED;
            end
        end else begin
            case (i_ctl.state)
                EV_TOUCHED: begin
                    if (elapsed > TPC_TIME_W'(i_cfg.short_press_ms)) begin
                        o_ctl.state = EV_SHORT;
                        o_emit      = 1'b1;
                        o_code      = EV_SHORT;
                    end
                end
                EV_SHORT: begin
                    if (elapsed > TPC_TIME_W'(i_cfg.long_press_ms)) begin
                        o_ctl.state = EV_LONG;
                        o_emit      = 1'b1;
                        o_code      = EV_LONG;
                    end
                end
                EV_LONG: begin
                    if (elapsed > TPC_TIME_W'(i_cfg.very_long_press_ms)) begin
                        o_ctl.state = EV_VERY_LONG;
                        o_emit      = 1'b1;
                        o_code      = EV_VERY_LONG;
                    end
                end
                EV_VERY_LONG: begin
                    // Force release of a stuck pad unless touch_enabled is set
                    if (elapsed > TPC_TIME_W'(i_cfg.stuck_release_ms) &&
                        !i_cfg.touch_enabled) begin
                        o_ctl.state       = EV_RELEASED;
                        o_ctl.change_time = i_now;
                        o_emit            = 1'b1;
                        o_code            = EV_RELEASED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/core/touch_pad_press_classifier_core.sv
// ----------------------------------------------------------------------------
// touch_pad_press_classifier_core
// Per-pad touch detection from raw capacitive samples, with short, long and
// very long press escalation and stuck-pad release. One event word at most
// per sample word.
// Pipeline: input register, then result register for the event word.
// Throughput: one sample word per cycle, except while a new event word waits
// for a pending one to be taken; the pad record is read, updated and written
// back between the two registers.
// Reset: synchronous, active low; all pads released with zeroed history and
// registers at their default values; no clearing pass.
// ----------------------------------------------------------------------------
module touch_pad_press_classifier_core #(
    parameter int NUM_PADS      = tpc_pkg::TPC_NUM_PADS,
    parameter int HISTORY_DEPTH = tpc_pkg::TPC_HISTORY_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tpc_pkg::t_in_item                   i_in_item,
    // Event channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tpc_pkg::t_out_item                  o_out_item,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [tpc_pkg::TPC_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpc_pkg::TPC_CFG_W-1:0]       i_cfg_wdata
);
    import tpc_pkg::*;

    localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = TPC_DELTA_W + $clog2(HISTORY_DEPTH);

    typedef logic [HISTORY_DEPTH-1:0][TPC_DELTA_W-1:0] t_ring_row;

    // Configuration
    t_cfg r_cfg;

    // Per-pad records
    t_pad_ctl                r_ctl  [NUM_PADS];
    t_ring_row               r_ring [NUM_PADS];
    logic [PTR_W-1:0]        r_ptr  [NUM_PADS];
    logic signed [SUM_W-1:0] r_sum  [NUM_PADS];

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic                    pad_ok;
    logic [PAD_W-1:0]        pad_sel;
    logic                    advance;
    t_pad_ctl                n_ctl;
    t_ring_row               n_ring;
    logic [PTR_W-1:0]        n_ptr;
    logic signed [SUM_W-1:0] n_sum;
    logic                    emit;
    t_event_code             code;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta_threshold    <= TPC_RST_THRESHOLD;
            r_cfg.short_press_ms     <= TPC_RST_SHORT_MS;
            r_cfg.long_press_ms      <= TPC_RST_LONG_MS;
            r_cfg.very_long_press_ms <= TPC_RST_VLONG_MS;
            r_cfg.stuck_release_ms   <= TPC_RST_STUCK_MS;
            r_cfg.touch_enabled      <= TPC_RST_TOUCH_EN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DELTA_THRESHOLD: r_cfg.delta_threshold    <= i_cfg_wdata;
                CFG_SHORT_PRESS_MS:  r_cfg.short_press_ms     <= i_cfg_wdata;
                CFG_LONG_PRESS_MS:   r_cfg.long_press_ms      <= i_cfg_wdata;
                CFG_VLONG_PRESS_MS:  r_cfg.very_long_press_ms <= i_cfg_wdata;
                CFG_STUCK_RELEASE:   r_cfg.stuck_release_ms   <= i_cfg_wdata;
                CFG_TOUCH_ENABLED:   r_cfg.touch_enabled      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Select the pad record of the registered sample
    assign pad_ok  = {1'b0, r_in.pad_index} < (TPC_PAD_FIELD_W + 1)'(NUM_PADS);
    assign pad_sel = r_in.pad_index[PAD_W-1:0];

    tpc_pad_update #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PTR_W         (PTR_W),
        .SUM_W         (SUM_W)
    ) u_pad_update (
        .i_cfg    (r_cfg),
        .i_sample (r_in.raw_sample),
        .i_now    (r_in.now_ms),
        .i_ctl    (r_ctl[pad_sel]),
        .i_ring   (r_ring[pad_sel]),
        .i_ptr    (r_ptr[pad_sel]),
        .i_sum    (r_sum[pad_sel]),
        .o_ctl    (n_ctl),
        .o_ring   (n_ring),
        .o_ptr    (n_ptr),
        .o_sum    (n_sum),
        .o_emit   (emit),
        .o_code   (code)
    );

    // Advance unless an event word would overwrite one still waiting
    assign advance    = r_in_valid && (!(emit && pad_ok) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Write back the pad record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PADS; p++) begin
                r_ctl[p].state       <= EV_RELEASED;
                r_ctl[p].change_time <= '0;
                r_ctl[p].last_sample <= '0;
                r_ring[p]            <= '0;
                r_ptr[p]             <= '0;
                r_sum[p]             <= '0;
            end
        end else if (advance && pad_ok) begin
            r_ctl[pad_sel]  <= n_ctl;
            r_ring[pad_sel] <= n_ring;
            r_ptr[pad_sel]  <= n_ptr;
            r_sum[pad_sel]  <= n_sum;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit && pad_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit && pad_ok) begin
            r_out.event_pad  <= r_in.pad_index;
            r_out.event_code <= code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // An event word carries the pad of the sample that caused it
    a_event_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit && pad_ok |=>
            o_out_valid && o_out_item.event_pad == $past(r_in.pad_index))
        else $error("event word does not match its sample");

    // A sample held back keeps its contents
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("stalled sample lost or changed");

    // A waiting event word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(advance && emit && pad_ok))
        else $error("pending event word overwritten");

    // Writes to unknown register indexes leave the registers alone
    a_cfg_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && i_cfg_index != CFG_DELTA_THRESHOLD &&
        i_cfg_index != CFG_SHORT_PRESS_MS && i_cfg_index != CFG_LONG_PRESS_MS &&
        i_cfg_index != CFG_VLONG_PRESS_MS && i_cfg_index != CFG_STUCK_RELEASE &&
        i_cfg_index != CFG_TOUCH_ENABLED |=> $stable(r_cfg))
        else $error("unknown register write changed configuration");

endmodule
